/* rtl/bsfb_pkg.sv */
// Package for the byte stuffing frame builder: shared types, constants and codes.
// Used by every module under rtl/ through scoped names; depends on nothing.
`timescale 1ns / 1ps

package bsfb_pkg;

  // Largest number of payload bytes kept in one frame.
  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned CountW     = 11;

  // Depth of the queue between front and back.
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCountW = $clog2(QDepth + 1);

  localparam int unsigned PAddrW = 5;

  // Configuration register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_FLAG      = 3'd0,
    REG_ESCAPE    = 3'd1,
    REG_FLAG_SUB  = 3'd2,
    REG_ESC_SUB   = 3'd3,
    REG_ADDRESS   = 3'd4,
    REG_CONTROL   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] flag_substitute;
    logic [7:0] escape_substitute;
    logic [7:0] address_value;
    logic [7:0] control_value;
  } cfg_t;

  // One classified input item as handed from front to back.
  typedef struct packed {
    logic       hdr;    // first byte of a frame: send header first
    logic       ovf;    // payload byte dropped, send error result
    logic       last;   // close the frame after this item
    logic [7:0] data;   // raw payload byte
    logic [7:0] chk;    // running check, including this byte unless it was dropped
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end sequencer steps for one entry.
  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_FLAG  = 4'd1,
    PH_ADDR  = 4'd2,
    PH_CTRL  = 4'd3,
    PH_HCHK  = 4'd4,
    PH_PAY   = 4'd5,
    PH_PAY2  = 4'd6,
    PH_CHK   = 4'd7,
    PH_CHK2  = 4'd8,
    PH_CLOSE = 4'd9
  } phase_e;

endpackage

/* rtl/byte_stuffing_frame_builder_core.sv */
// Top level of the byte stuffing frame builder: APB registers, front, queue and back.
// Instantiates bsfb_front, bsfb_queue and bsfb_back; uses bsfb_pkg.
`timescale 1ns / 1ps

// Channel  | Dir | Transfer when                      | Payload
// s_axis   | in  | s_axis_tvalid_i & s_axis_tready_o   | tdata = payload byte, tlast = last of frame
// m_axis   | out | m_axis_tvalid_o & m_axis_tready_i   | tdata = line byte, tlast = run end,
//          |     |                                     | tuser = overflow (dropped byte)
// apb      | in  | psel_i & penable_i & pwrite_i       | six 8-bit registers at 4 * index
//
// The back end emits one line byte per cycle while m_axis is ready and an entry is queued:
// a plain payload byte gives one line byte, a stuffed one two, the first byte of a frame
// four more for the header and the last byte two or three more for the check and closing flag.
// The front end takes one transfer per cycle while the four-entry queue has room.
// Reset is asynchronous, active low; it closes any open frame and empties the queue.
// A stalled m_axis holds its byte in the output register; the queue keeps taking input until full.

module byte_stuffing_frame_builder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] payload_byte
  input  logic                          s_axis_tlast_i,
  // Output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,   // [7:0] line_byte
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tuser_o,   // [0] overflow
  // Configuration port
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [bsfb_pkg::PAddrW-1:0]   paddr_i,
  input  logic [31:0]                   pwdata_i,
  output logic [31:0]                   prdata_o,
  output logic                          pready_o
);

  bsfb_pkg::cfg_t    cfg_q, cfg_d;
  bsfb_pkg::entry_t  front_entry;
  bsfb_pkg::entry_t  head_entry;
  bsfb_pkg::q_stat_t q_stat;
  logic              q_pop;
  logic              cfg_wr;
  bsfb_pkg::reg_idx_e reg_idx;

  // Configuration registers: written on the access cycle, read back as 8 bits.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign reg_idx  = bsfb_pkg::reg_idx_e'(paddr_i[bsfb_pkg::PAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        bsfb_pkg::REG_FLAG:     cfg_d.flag_value        = pwdata_i[7:0];
        bsfb_pkg::REG_ESCAPE:   cfg_d.escape_value      = pwdata_i[7:0];
        bsfb_pkg::REG_FLAG_SUB: cfg_d.flag_substitute   = pwdata_i[7:0];
        bsfb_pkg::REG_ESC_SUB:  cfg_d.escape_substitute = pwdata_i[7:0];
        bsfb_pkg::REG_ADDRESS:  cfg_d.address_value     = pwdata_i[7:0];
        bsfb_pkg::REG_CONTROL:  cfg_d.control_value     = pwdata_i[7:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata_o = 32'd0;
    case (reg_idx)
      bsfb_pkg::REG_FLAG:     prdata_o = {24'd0, cfg_q.flag_value};
      bsfb_pkg::REG_ESCAPE:   prdata_o = {24'd0, cfg_q.escape_value};
      bsfb_pkg::REG_FLAG_SUB: prdata_o = {24'd0, cfg_q.flag_substitute};
      bsfb_pkg::REG_ESC_SUB:  prdata_o = {24'd0, cfg_q.escape_substitute};
      bsfb_pkg::REG_ADDRESS:  prdata_o = {24'd0, cfg_q.address_value};
      bsfb_pkg::REG_CONTROL:  prdata_o = {24'd0, cfg_q.control_value};
      default:                prdata_o = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_value        <= 8'd126;
      cfg_q.escape_value      <= 8'd125;
      cfg_q.flag_substitute   <= 8'd94;
      cfg_q.escape_substitute <= 8'd93;
      cfg_q.address_value     <= 8'd3;
      cfg_q.control_value     <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Accept input whenever the queue has room.
  assign s_axis_tready_o = !q_stat.full;

  // Classify each byte: header needed, overflow, running check.
  bsfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_i (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .entry_o    (front_entry)
  );

  // Hold classified items until the back end gets to them.
  bsfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid_i),
    .push_entry_i (front_entry),
    .pop_i        (q_pop),
    .head_o       (head_entry),
    .stat_o       (q_stat)
  );

  // Expand each item into header, stuffed bytes, check and closing flag.
  bsfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head_entry),
    .q_empty_i   (q_stat.empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_user_o  (m_axis_tuser_o)
  );

  // An error result carries no line byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'd0)
    else $error("overflow result carries a nonzero line byte");

  // The queue is never full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // A transfer in always leaves at least one entry queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !q_stat.empty)
    else $error("accepted item lost from queue");

endmodule

/* rtl/bsfb_front.sv */
// Front end of the frame builder: accepts payload bytes and classifies them.
// Tracks frame state, running check and payload count; uses bsfb_pkg.
`timescale 1ns / 1ps

module bsfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_data_i,
  input  logic              in_last_i,
  output bsfb_pkg::entry_t  entry_o
);

  logic                          inside_q, inside_d;
  logic [7:0]                    chk_q, chk_d;
  logic [bsfb_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic [7:0]                    base_chk;
  logic [bsfb_pkg::CountW-1:0]   base_cnt;
  logic                          ovf;
  logic [7:0]                    chk_new;
  logic [bsfb_pkg::CountW-1:0]   cnt_new;

  always_comb begin
    base_chk = inside_q ? chk_q : 8'd0;
    base_cnt = inside_q ? cnt_q : '0;
    ovf      = (base_cnt >= bsfb_pkg::CountW'(bsfb_pkg::MaxPayload));
    chk_new  = ovf ? base_chk : (base_chk ^ in_data_i);
    cnt_new  = ovf ? base_cnt : (base_cnt + bsfb_pkg::CountW'(1));

    entry_o.hdr  = !inside_q;
    entry_o.ovf  = ovf;
    entry_o.last = in_last_i;
    entry_o.data = in_data_i;
    entry_o.chk  = chk_new;
  end

  always_comb begin
    inside_d = inside_q;
    chk_d    = chk_q;
    cnt_d    = cnt_q;
    if (in_valid_i && in_ready_i) begin
      if (in_last_i) begin
        inside_d = 1'b0;
        chk_d    = 8'd0;
        cnt_d    = '0;
      end else begin
        inside_d = 1'b1;
        chk_d    = chk_new;
        cnt_d    = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      chk_q    <= 8'd0;
      cnt_q    <= '0;
    end else begin
      inside_q <= inside_d;
      chk_q    <= chk_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/bsfb_queue.sv */
// Short entry queue that decouples the front end from the back end.
// Register array with read and write pointers; uses bsfb_pkg.
`timescale 1ns / 1ps

module bsfb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bsfb_pkg::entry_t  push_entry_i,
  input  logic              pop_i,
  output bsfb_pkg::entry_t  head_o,
  output bsfb_pkg::q_stat_t stat_o
);

  bsfb_pkg::entry_t                mem [bsfb_pkg::QDepth];
  logic [bsfb_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [bsfb_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [bsfb_pkg::QCountW-1:0]    count_q, count_d;
  logic                            do_push, do_pop;

  always_comb begin
    stat_o.full  = (count_q == bsfb_pkg::QCountW'(bsfb_pkg::QDepth));
    stat_o.empty = (count_q == '0);
    do_push      = push_i && !stat_o.full;
    do_pop       = pop_i && !stat_o.empty;
    wr_ptr_d     = do_push ? wr_ptr_q + bsfb_pkg::QPtrW'(1) : wr_ptr_q;
    rd_ptr_d     = do_pop ? rd_ptr_q + bsfb_pkg::QPtrW'(1) : rd_ptr_q;
    count_d      = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + bsfb_pkg::QCountW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - bsfb_pkg::QCountW'(1);
    end
    head_o = mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/bsfb_back.sv */
// Back end of the frame builder: walks each queued entry and emits line bytes.
// Header, stuffing, check and closing flag sequencer plus output register; uses bsfb_pkg.
`timescale 1ns / 1ps

module bsfb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsfb_pkg::cfg_t    cfg_i,
  input  bsfb_pkg::entry_t  head_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_data_o,
  output logic              out_last_o,
  output logic              out_user_o
);

  bsfb_pkg::phase_e phase_q, phase_d, cur_phase, after_pay;
  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic       user_q, user_d;
  logic       load, step;
  logic [7:0] byte_val;
  logic       byte_user;
  logic       done;
  bsfb_pkg::phase_e next_phase;

  assign load = !valid_q || out_ready_i;
  assign step = load && !q_empty_i;

  // Next-step logic for the sequencer
  always_comb begin
    cur_phase = phase_q;
    if (phase_q == bsfb_pkg::PH_START) begin
      cur_phase = head_i.hdr ? bsfb_pkg::PH_FLAG : bsfb_pkg::PH_PAY;
    end
    after_pay  = head_i.last ? bsfb_pkg::PH_CHK : bsfb_pkg::PH_START;
    next_phase = bsfb_pkg::PH_START;
    case (cur_phase)
      bsfb_pkg::PH_FLAG: next_phase = bsfb_pkg::PH_ADDR;
      bsfb_pkg::PH_ADDR: next_phase = bsfb_pkg::PH_CTRL;
      bsfb_pkg::PH_CTRL: next_phase = bsfb_pkg::PH_HCHK;
      bsfb_pkg::PH_HCHK: next_phase = bsfb_pkg::PH_PAY;
      bsfb_pkg::PH_PAY: begin
        if (!head_i.ovf && (head_i.data == cfg_i.flag_value ||
                            head_i.data == cfg_i.escape_value)) begin
          next_phase = bsfb_pkg::PH_PAY2;
        end else begin
          next_phase = after_pay;
        end
      end
      bsfb_pkg::PH_PAY2: next_phase = after_pay;
      bsfb_pkg::PH_CHK: begin
        if (head_i.chk == cfg_i.flag_value || head_i.chk == cfg_i.escape_value) begin
          next_phase = bsfb_pkg::PH_CHK2;
        end else begin
          next_phase = bsfb_pkg::PH_CLOSE;
        end
      end
      bsfb_pkg::PH_CHK2:  next_phase = bsfb_pkg::PH_CLOSE;
      bsfb_pkg::PH_CLOSE: next_phase = bsfb_pkg::PH_START;
      default:            next_phase = bsfb_pkg::PH_START;
    endcase
    done    = (next_phase == bsfb_pkg::PH_START);
    phase_d = step ? next_phase : phase_q;
  end

  // Byte selection for the current step
  always_comb begin
    byte_val  = 8'd0;
    byte_user = 1'b0;
    case (cur_phase)
      bsfb_pkg::PH_FLAG: byte_val = cfg_i.flag_value;
      bsfb_pkg::PH_ADDR: byte_val = cfg_i.address_value;
      bsfb_pkg::PH_CTRL: byte_val = cfg_i.control_value;
      bsfb_pkg::PH_HCHK: byte_val = cfg_i.address_value ^ cfg_i.control_value;
      bsfb_pkg::PH_PAY: begin
        if (head_i.ovf) begin
          byte_user = 1'b1;
        end else if (head_i.data == cfg_i.flag_value ||
                     head_i.data == cfg_i.escape_value) begin
          byte_val = cfg_i.escape_value;
        end else begin
          byte_val = head_i.data;
        end
      end
      bsfb_pkg::PH_PAY2: byte_val = (head_i.data == cfg_i.flag_value) ?
                                    cfg_i.flag_substitute : cfg_i.escape_substitute;
      bsfb_pkg::PH_CHK: begin
        if (head_i.chk == cfg_i.flag_value || head_i.chk == cfg_i.escape_value) begin
          byte_val = cfg_i.escape_value;
        end else begin
          byte_val = head_i.chk;
        end
      end
      bsfb_pkg::PH_CHK2: byte_val = (head_i.chk == cfg_i.flag_value) ?
                                    cfg_i.flag_substitute : cfg_i.escape_substitute;
      bsfb_pkg::PH_CLOSE: byte_val = cfg_i.flag_value;
      default:            byte_val = 8'd0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    user_d  = user_q;
    if (load) begin
      valid_d = step;
      data_d  = byte_val;
      last_d  = done;
      user_d  = byte_user;
    end
  end

  assign pop_o       = step && done;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;
  assign out_user_o  = user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bsfb_pkg::PH_START;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    user_q <= user_d;
  end

endmodule

/* sim/line_stream_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the byte stuffing frame builder: tracks register writes, predicts the
// line bytes of every payload transfer and compares them with the output stream.
// Depends on bsfb_pkg for the register indexes, the configuration struct and the payload limit.

module line_stream_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_i,
  input  logic [7:0]                  s_axis_tdata_i,   // [7:0] payload_byte
  input  logic                        s_axis_tlast_i,
  input  logic                        m_axis_tvalid_i,
  input  logic                        m_axis_tready_i,
  input  logic [7:0]                  m_axis_tdata_i,   // [7:0] line_byte
  input  logic                        m_axis_tlast_i,
  input  logic                        m_axis_tuser_i,   // [0] overflow
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [bsfb_pkg::PAddrW-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output int                          mismatch_count_o,
  output int                          pending_o
);
  import bsfb_pkg::*;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
    logic       overflow;
  } line_item_t;

  localparam cfg_t CfgReset = '{
    flag_value:        8'd126,
    escape_value:      8'd125,
    flag_substitute:   8'd94,
    escape_substitute: 8'd93,
    address_value:     8'd3,
    control_value:     8'd0
  };

  line_item_t        line_q[$];
  cfg_t              cfg;
  logic              in_frame;
  logic [7:0]        frame_xor;
  logic [CountW-1:0] frame_len;
  int                mismatches;

  function automatic void push_line(logic [7:0] b, logic ovf);
    line_item_t item;
    item.line_byte = b;
    item.run_end   = 1'b0;
    item.overflow  = ovf;
    line_q.push_back(item);
  endfunction

  function automatic void push_stuffed(logic [7:0] b);
    if (b == cfg.flag_value) begin
      push_line(cfg.escape_value, 1'b0);
      push_line(cfg.flag_substitute, 1'b0);
    end else if (b == cfg.escape_value) begin
      push_line(cfg.escape_value, 1'b0);
      push_line(cfg.escape_substitute, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  // Line bytes caused by one payload transfer; the last of them carries tlast.
  function automatic void predict_line_bytes(logic [7:0] data, logic last);
    line_item_t tail;
    if (!in_frame) begin
      push_line(cfg.flag_value, 1'b0);
      push_line(cfg.address_value, 1'b0);
      push_line(cfg.control_value, 1'b0);
      push_line(cfg.address_value ^ cfg.control_value, 1'b0);
      in_frame  = 1'b1;
      frame_xor = '0;
      frame_len = '0;
    end
    if (frame_len >= CountW'(MaxPayload)) begin
      push_line(8'h00, 1'b1);
    end else begin
      push_stuffed(data);
      frame_xor = frame_xor ^ data;
      frame_len = frame_len + CountW'(1);
    end
    if (last) begin
      push_stuffed(frame_xor);
      push_line(cfg.flag_value, 1'b0);
      in_frame  = 1'b0;
      frame_xor = '0;
      frame_len = '0;
    end
    tail = line_q.pop_back();
    tail.run_end = 1'b1;
    line_q.push_back(tail);
  endfunction

  function automatic void check_line_byte(logic [7:0] b, logic run_end, logic ovf);
    line_item_t want;
    if (line_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected line byte %02h tlast %0b tuser %0b", b, run_end, ovf);
    end else begin
      want = line_q.pop_front();
      if (want.line_byte !== b || want.run_end !== run_end || want.overflow !== ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("line byte mismatch (byte/tlast/tuser): expected %02h/%0b/%0b got %02h/%0b/%0b",
                   want.line_byte, want.run_end, want.overflow, b, run_end, ovf);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q.delete();
      cfg        = CfgReset;
      in_frame   = 1'b0;
      frame_xor  = '0;
      frame_len  = '0;
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PAddrW-1:2]))
          REG_FLAG:     cfg.flag_value        = pwdata_i[7:0];
          REG_ESCAPE:   cfg.escape_value      = pwdata_i[7:0];
          REG_FLAG_SUB: cfg.flag_substitute   = pwdata_i[7:0];
          REG_ESC_SUB:  cfg.escape_substitute = pwdata_i[7:0];
          REG_ADDRESS:  cfg.address_value     = pwdata_i[7:0];
          REG_CONTROL:  cfg.control_value     = pwdata_i[7:0];
          default: ;
        endcase
      end
      // Retire the output transfer before adding new expectations.
      if (m_axis_tvalid_i && m_axis_tready_i)
        check_line_byte(m_axis_tdata_i, m_axis_tlast_i, m_axis_tuser_i);
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_line_bytes(s_axis_tdata_i, s_axis_tlast_i);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= line_q.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Top of the byte stuffing frame builder testbench: clock, reset, payload and register
// stimulus, output back-pressure and the verdict. Needs the RTL, bsfb_pkg and
// line_stream_checker, which predicts and compares every line byte.

module tb_top;
  import bsfb_pkg::*;

  localparam int WatchdogLimit = 2000;  // cycles without any transfer before giving up
  localparam int HoldOffCycles = 300;   // one long output stall to back up the queue
  localparam int SettleCycles  = 16;    // let the back end go quiet before a register write
  localparam int PhaseItems    = 40;    // payload transfers per random phase

  localparam cfg_t CfgReset = '{
    flag_value:        8'd126,
    escape_value:      8'd125,
    flag_substitute:   8'd94,
    escape_substitute: 8'd93,
    address_value:     8'd3,
    control_value:     8'd0
  };

  typedef enum {
    CFG_DEFAULT,
    CFG_SHARED_ESCAPE,
    CFG_RANDOM,
    CFG_SUB_CLASH
  } cfg_style_e;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = 8'h00;
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  logic              m_tuser;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [PAddrW-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  int   mismatch_count;
  int   pending;
  int   idle_cycles   = 0;
  bit   hold_off_req  = 1'b0;
  bit   hold_off_done = 1'b0;
  cfg_t wr_cfg        = CfgReset;   // what the registers hold, for biasing payload bytes

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_stuffing_frame_builder_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),    // [7:0] payload_byte
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),    // [7:0] line_byte
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),    // [0] overflow
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  line_stream_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tlast_i   (s_tlast),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .m_axis_tlast_i   (m_tlast),
    .m_axis_tuser_i   (m_tuser),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Sender gaps: half the transfers go back to back, a few wait a long while.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int receiver_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Favor bytes that hit the stuffing rules or equal a substitute.
  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return wr_cfg.flag_value;
    if (r < 30) return wr_cfg.escape_value;
    if (r < 35) return wr_cfg.flag_substitute;
    if (r < 40) return wr_cfg.escape_substitute;
    return 8'($urandom);
  endfunction

  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic cfg_t pick_config(cfg_style_e style);
    cfg_t c;
    c.flag_value        = 8'($urandom);
    c.escape_value      = 8'($urandom);
    c.flag_substitute   = 8'($urandom);
    c.escape_substitute = 8'($urandom);
    c.address_value     = 8'($urandom);
    c.control_value     = 8'($urandom);
    case (style)
      CFG_DEFAULT:       c = CfgReset;
      CFG_SHARED_ESCAPE: c.escape_value = c.flag_value;
      CFG_SUB_CLASH: begin
        // substitutes and header bytes that look like delimiters go out unstuffed
        c.flag_substitute   = c.flag_value;
        c.escape_substitute = c.escape_value;
        c.address_value     = c.escape_value;
        c.control_value     = c.flag_value ^ c.escape_value ^ c.address_value;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Setup cycle, access cycle, then idle so psel is never lowered and
  // raised in the same step.
  task automatic apb_write(reg_idx_e idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    apb_write(REG_FLAG, c.flag_value);
    apb_write(REG_ESCAPE, c.escape_value);
    apb_write(REG_FLAG_SUB, c.flag_substitute);
    apb_write(REG_ESC_SUB, c.escape_substitute);
    apb_write(REG_ADDRESS, c.address_value);
    apb_write(REG_CONTROL, c.control_value);
    wr_cfg = c;
  endtask

  // Offer one payload byte, hold it until the transfer, then maybe idle.
  task automatic send_payload(logic [7:0] b, logic last);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random frame; now and then pick the last byte so the payload check itself
  // needs stuffing.
  task automatic send_frame(int len);
    logic [7:0] run_xor;
    logic [7:0] b;
    run_xor = 8'h00;
    for (int i = 0; i < len; i++) begin
      b = pick_payload();
      if (i == len - 1 && $urandom_range(0, 3) == 0)
        b = run_xor ^ ($urandom_range(0, 1) ? wr_cfg.flag_value : wr_cfg.escape_value);
      send_payload(b, i == len - 1);
      run_xor = run_xor ^ b;
    end
  endtask

  // Stop offering and wait until every predicted line byte has come out. The
  // count from the checker is registered.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Output side: ready bursts, short and long stalls, and one long hold-off on request.
  initial begin : line_receiver
    int run_len;
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 99) < 15) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else begin
        gap = receiver_gap();
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Give up when neither stream moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : payload_stimulus
    int   sent;
    cfg_t c;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: delimiters in the payload, substitutes as plain bytes,
    // and one-byte frames whose check equals the flag, then the escape.
    send_payload(8'h00, 1'b0);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h7E, 1'b0);
    send_payload(8'h7D, 1'b0);
    send_payload(8'h5E, 1'b0);
    send_payload(8'h5D, 1'b0);
    send_payload(8'h80, 1'b1);
    send_payload(8'h7E, 1'b1);
    send_payload(8'h7D, 1'b1);
    drain();

    // All registers zero: flag and escape equal, substitutes equal to both.
    c = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    load_config(c);
    send_payload(8'h00, 1'b0);
    send_payload(8'h01, 1'b0);
    send_payload(8'h00, 1'b1);
    send_payload(8'h00, 1'b1);
    drain();

    // All registers at the top of their range.
    c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    load_config(c);
    send_payload(8'hFF, 1'b0);
    send_payload(8'hFE, 1'b0);
    send_payload(8'h01, 1'b1);
    send_payload(8'hFF, 1'b1);
    drain();

    // Header check equal to the flag, substitutes swapped with the delimiters.
    c.flag_value        = 8'hFF;
    c.escape_value      = 8'h00;
    c.flag_substitute   = 8'h00;
    c.escape_substitute = 8'hFF;
    c.address_value     = 8'hAA;
    c.control_value     = 8'h55;
    load_config(c);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h00, 1'b0);
    send_payload(8'hAA, 1'b1);
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       load_config(pick_config(CFG_DEFAULT));
        1:       load_config(pick_config(CFG_SHARED_ESCAPE));
        2:       load_config(pick_config(CFG_RANDOM));
        default: load_config(pick_config(CFG_SUB_CLASH));
      endcase
      // back the output up while the input keeps offering
      if (phase == 2) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        c.control_value = 8'(pick_frame_len());
        send_frame(int'(c.control_value));
        sent += int'(c.control_value);
      end
      drain();
    end

    if (mismatch_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bsfb_pkg.sv
rtl/bsfb_front.sv
rtl/bsfb_queue.sv
rtl/bsfb_back.sv
rtl/byte_stuffing_frame_builder_core.sv
sim/line_stream_checker.sv
sim/tb_top.sv
